>>> rtl/kxd_pkg.sv
// Shared constants, tables and the generator step function for the keystream XOR decryptor.
// This file has no dependencies. The top level uses it by scoped names.
`timescale 1ns / 1ps

package kxd_pkg;

  localparam int unsigned KsLength = 256;
  localparam int unsigned PosW     = $clog2(KsLength);

  localparam logic [31:0] GenXor = 32'h9a87df9f;
  localparam logic [31:0] GenMul = 32'd13;
  localparam int unsigned ModW   = 19;
  localparam int unsigned SumW   = 20;
  localparam logic [ModW-1:0] GenMod = 19'h54781;

  localparam logic [63:0] StepHi  = (64'd1 << 24) % 64'h54781;
  localparam logic [63:0] StepMid = (64'd1 << 16) % 64'h54781;

  typedef logic [255:0][ModW-1:0] mod_tbl_t;

  function automatic mod_tbl_t build_tbl(input logic [ModW-1:0] step);
    mod_tbl_t        tbl;
    logic [ModW:0]   acc;
    acc = '0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = acc[ModW-1:0];
      acc = acc + {1'b0, step};
      if (acc >= {1'b0, GenMod}) begin
        acc = acc - {1'b0, GenMod};
      end
    end
    return tbl;
  endfunction

  localparam mod_tbl_t HiTbl  = build_tbl(StepHi[ModW-1:0]);
  localparam mod_tbl_t MidTbl = build_tbl(StepMid[ModW-1:0]);

  // One generator step: the product is reduced by table look-ups for its two upper bytes,
  // then brought below the modulus by one of two constant subtractions.
  function automatic logic [31:0] gen_step(input logic [31:0] g);
    logic [31:0]     t;
    logic [SumW-1:0] sum;
    logic [SumW-1:0] red;
    t   = (g ^ GenXor) * GenMul;
    sum = SumW'(HiTbl[t[31:24]]) + SumW'(MidTbl[t[23:16]]) + SumW'(t[15:0]);
    if (sum >= {GenMod, 1'b0}) begin
      red = sum - {GenMod, 1'b0};
    end else if (sum >= SumW'(GenMod)) begin
      red = sum - SumW'(GenMod);
    end else begin
      red = sum;
    end
    return {{(32 - ModW + 2){1'b0}}, red[ModW-1:2]};
  endfunction

endpackage

>>> rtl/keystream_xor_decrypt.sv
// Top level of the keystream XOR decryptor: generator, keystream table and output register.
// Depends on kxd_pkg for constants, reduction tables and the generator step.
`timescale 1ns / 1ps

// The block takes one item per cycle while its input is not stalled. Its result passes
// through two stages, the input stage (generator step and table write), where a result
// stall can hold it, and the result register at the output. The generator step, a
// constant multiply followed by a table-based modulo reduction, is combinational, so a
// byte may follow every unstalled cycle. The 256-entry keystream table is a memory
// with a registered read; it needs no clearing pass, as an entry is only read after it
// has been written. Writing the key takes effect at the next item marked as a first byte.
module keystream_xor_decrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_user_key,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cipher_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_plain_byte,
  output logic        out_end_of_buffer
);

  logic [31:0]              seed_r;
  logic [31:0]              gen_r;
  logic [31:0]              gen_nxt;
  logic [31:0]              g_in;
  logic [31:0]              g_step;
  logic [kxd_pkg::PosW-1:0] pos_r;
  logic [kxd_pkg::PosW-1:0] pos_nxt;
  logic [kxd_pkg::PosW-1:0] pos_cur;
  logic                     complete_r;
  logic                     complete_nxt;
  logic                     comp_cur;

  logic [7:0]               ks_mem [kxd_pkg::KsLength];
  logic [7:0]               rd_r;

  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  logic [7:0]               s1_cipher_r;
  logic                     s1_last_r;
  logic [7:0]               s1_ks_r;
  logic                     s1_use_tbl_r;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [7:0]               out_plain_r;
  logic                     out_eob_r;

  logic                     in_acc;
  logic                     out_free;
  logic                     s1_move;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    pos_cur      = in_first_byte ? '0 : pos_r;
    comp_cur     = in_first_byte ? 1'b0 : complete_r;
    g_in         = in_first_byte ? seed_r : gen_r;
    g_step       = kxd_pkg::gen_step(g_in);
    gen_nxt      = comp_cur ? g_in : g_step;
    pos_nxt      = pos_cur + {{(kxd_pkg::PosW-1){1'b0}}, 1'b1};
    complete_nxt = comp_cur || (pos_nxt == '0);
    s1_valid_nxt = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_user_key * kxd_pkg::GenMul;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r      <= '0;
      pos_r      <= '0;
      complete_r <= 1'b0;
    end else if (in_acc) begin
      gen_r      <= gen_nxt;
      pos_r      <= pos_nxt;
      complete_r <= complete_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !comp_cur) begin
      ks_mem[pos_cur] <= g_step[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= ks_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cipher_r  <= in_cipher_byte;
      s1_last_r    <= in_last_byte;
      s1_ks_r      <= g_step[7:0];
      s1_use_tbl_r <= comp_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_plain_r <= s1_cipher_r ^ (s1_use_tbl_r ? rd_r : s1_ks_r);
      out_eob_r   <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_plain_byte    = out_plain_r;
  assign out_end_of_buffer = out_eob_r;

endmodule

>>> rtl/kxd_checker.sv
// Port-level checker for the keystream XOR decryptor, bound to the top level.
// Depends only on the top level's ports; has no package dependency.
`timescale 1ns / 1ps

module kxd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_user_key,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_cipher_byte,
  input logic        in_first_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_plain_byte,
  input logic        out_end_of_buffer
);

  logic unused_ok;
  assign unused_ok = cfg_valid & cfg_ready & (|cfg_user_key) & (|in_cipher_byte) &
                     in_first_byte & in_last_byte;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_plain_byte) && $stable(out_end_of_buffer))
    else $error("stalled result item changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result item appeared without an item accepted two cycles before");

endmodule

bind keystream_xor_decrypt kxd_checker u_kxd_checker (.*);

>>> tb/kxd_plain_checker.sv
// Checker for the keystream XOR decryptor: watches the key write, input and result channels,
// predicts each plain byte from its own copy of the keystream state and compares in order.
// Self-contained; it needs neither the package nor the RTL.
`timescale 1ns / 1ps

module kxd_plain_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_user_key,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_cipher_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_plain_byte,
  input  logic        out_end_of_buffer,
  output int          n_pending,
  output int          n_mismatch
);

  localparam logic [31:0] MixXor = 32'h9a87_df9f;
  localparam logic [31:0] MixMul = 32'd13;
  localparam logic [31:0] MixMod = 32'h0005_4781;

  typedef struct packed {
    logic [7:0] plain;
    logic       eob;
  } plain_item_t;

  logic [31:0] key_r;
  logic [31:0] gen_r;
  logic [7:0]  ks_mem [0:255];
  logic [7:0]  pos_r;
  logic        wrapped_r;
  plain_item_t plain_expected_q [$];
  int          errs = 0;

  function automatic logic [31:0] step_keystream(input logic [31:0] g);
    logic [31:0] prod;
    prod = (g ^ MixXor) * MixMul;
    return (prod % MixMod) >> 2;
  endfunction

  // Advances the keystream state by one item and returns the plain byte it yields.
  function automatic plain_item_t decrypt_byte(input logic [7:0] cb, input logic fb,
                                               input logic lb);
    plain_item_t res;
    if (fb) begin
      gen_r     = key_r * MixMul;
      pos_r     = '0;
      wrapped_r = 1'b0;
    end
    if (!wrapped_r) begin
      gen_r         = step_keystream(gen_r);
      ks_mem[pos_r] = gen_r[7:0];
    end
    res.plain = cb ^ ks_mem[pos_r];
    res.eob   = lb;
    pos_r     = pos_r + 8'd1;
    if (pos_r == 8'd0) begin
      wrapped_r = 1'b1;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    if (errs < 10) begin
      $display("%0t ns: %s", $time, msg);
    end
    errs++;
  endtask

  always @(posedge clk) begin : watch_channels
    plain_item_t want;
    if (!rst_n) begin
      key_r     = '0;
      gen_r     = '0;
      pos_r     = '0;
      wrapped_r = 1'b0;
      plain_expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_r = cfg_user_key;
      end
      if (out_valid && !out_stall) begin
        if (plain_expected_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: plain_byte %h, eob %b",
                                  out_plain_byte, out_end_of_buffer));
        end else begin
          want = plain_expected_q.pop_front();
          if (out_plain_byte !== want.plain) begin
            note_mismatch($sformatf("plain_byte: expected %h, got %h",
                                    want.plain, out_plain_byte));
          end
          if (out_end_of_buffer !== want.eob) begin
            note_mismatch($sformatf("end_of_buffer: expected %b, got %b",
                                    want.eob, out_end_of_buffer));
          end
        end
      end
      if (in_valid && !in_stall) begin
        plain_expected_q.push_back(decrypt_byte(in_cipher_byte, in_first_byte, in_last_byte));
      end
    end
    n_pending  <= plain_expected_q.size();
    n_mismatch <= errs;
  end

endmodule

>>> tb/tb_keystream_xor_decrypt.sv
// Top of the keystream XOR decryptor testbench: clock, reset, key writes, byte stimulus,
// result stalls, watchdog and verdict. Depends on the RTL top level and kxd_plain_checker.
`timescale 1ns / 1ps

module tb_keystream_xor_decrypt;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 300;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_user_key   = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_cipher_byte = '0;
  logic        in_first_byte  = 1'b0;
  logic        in_last_byte   = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_plain_byte;
  logic        out_end_of_buffer;

  int n_pending;
  int n_mismatch;
  int idle_cycles = 0;
  bit gaps_on     = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  always #5 clk = ~clk;

  keystream_xor_decrypt i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_user_key     (cfg_user_key),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cipher_byte   (in_cipher_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_byte   (out_plain_byte),
    .out_end_of_buffer(out_end_of_buffer)
  );

  kxd_plain_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_user_key     (cfg_user_key),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cipher_byte   (in_cipher_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_byte   (out_plain_byte),
    .out_end_of_buffer(out_end_of_buffer),
    .n_pending        (n_pending),
    .n_mismatch       (n_mismatch)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The long hold-off lets the block fill up and stall its input while bytes keep coming.
  initial begin : result_side
    int n;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer_byte(input logic [7:0] cb, input logic fb, input logic lb);
    int n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cipher_byte <= cb;
    in_first_byte  <= fb;
    in_last_byte   <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_key(input logic [31:0] k);
    cfg_valid    <= 1'b1;
    cfg_user_key <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_buffer(input int len, input bit marked_start, input bit marked_end);
    logic fb;
    logic lb;
    for (int i = 0; i < len; i++) begin
      fb = (i == 0) ? marked_start : ($urandom_range(0, 99) == 0);
      lb = (i == len - 1) ? marked_end : ($urandom_range(0, 39) == 0);
      offer_byte(8'($urandom_range(0, 255)), fb, lb);
    end
  endtask

  initial begin : stimulus
    logic [31:0] keys [6];
    int          sent;
    int          len;
    keys[0] = 32'h0000_0000;
    keys[1] = 32'hFFFF_FFFF;
    keys[2] = 32'h8000_0000;
    keys[3] = $urandom();
    keys[4] = 32'h0000_0001;
    keys[5] = $urandom();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Without a first byte after reset the generator runs on from its reset value.
    offer_byte(8'h00, 1'b0, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(8'h5A, 1'b0, 1'b1);
    offer_byte(8'hC3, 1'b0, 1'b0);
    offer_byte(8'hFF, 1'b1, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b1);
    offer_byte(8'h81, 1'b1, 1'b1);
    drain_results();

    load_key(32'hFFFF_FFFF);
    offer_byte(8'h00, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(8'hA5, 1'b0, 1'b1);
    offer_byte(8'h5A, 1'b0, 1'b0);
    drain_results();

    // A new key in the middle of a buffer only counts from the next first byte.
    load_key(32'h0000_0001);
    offer_byte(8'h3C, 1'b0, 1'b0);
    offer_byte(8'h96, 1'b0, 1'b1);
    offer_byte(8'h69, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b1);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      gaps_on = (p < 5);
      load_key(keys[p]);
      sent = 0;
      if (p == 1) begin
        hold_req = 1'b1;
        run_buffer(320, 1'b1, 1'b1);
        sent = 320;
      end
      while (sent < 30) begin
        if ($urandom_range(0, 14) == 0) begin
          len = $urandom_range(257, 300);
        end else begin
          len = $urandom_range(1, 40);
        end
        run_buffer(len, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
        sent += len;
      end
      drain_results();
    end

    repeat (10) @(negedge clk);
    if (n_mismatch == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
